[rtl/core/cfd_pkg.sv]
// Shared types, codes and CRC helpers for the CRC-32 framed packet deframer.
// No dependencies; cfd_crc_unit and the top level use this package.
`timescale 1ns / 1ps

package cfd_pkg;

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_TOP  = 32'h8000_0000;

    typedef enum logic [1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1,
        CFG_SYNC_THIRD  = 2'd2,
        CFG_MAX_LEN     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_PAYLOAD  = 2'd0,
        ST_EMPTY_OK = 2'd1,
        ST_CRC_ERR  = 2'd2,
        ST_LEN_ERR  = 2'd3
    } t_status;

    typedef enum logic [5:0] {
        PH_H1   = 6'b000001,
        PH_H2   = 6'b000010,
        PH_H3   = 6'b000100,
        PH_LEN  = 6'b001000,
        PH_DATA = 6'b010000,
        PH_CRC  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic        load;
        logic        fresh;
        logic [31:0] word;
    } t_crc_cmd;

    function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] word);
        logic [31:0] c;
        c = crc ^ word;
        for (int i = 0; i < 32; i++) begin
            if ((c & CRC_TOP) != 32'd0) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/core/cfd_in_if.sv]
// Input byte channel of the deframer: valid, ready and the received byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface cfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/core/cfd_out_if.sv]
// Result channel of the deframer: valid, ready, status, payload byte, last flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface cfd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] payload_byte;
    logic       last;

    modport source (output valid, output status, output payload_byte, output last,
                    input ready);
    modport sink   (input valid, input status, input payload_byte, input last,
                    output ready);
endinterface

[rtl/core/cfd_crc_unit.sv]
// Word-wise CRC-32 register: folds one 32-bit word in during the cycle of its load.
// Depends on cfd_pkg for the command struct and the word function.
`timescale 1ns / 1ps

module cfd_crc_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfd_pkg::t_crc_cmd i_cmd,
    output logic [31:0]       o_crc
);

    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [31:0] w_base;

    assign o_crc  = r_crc;
    assign w_base = i_cmd.fresh ? cfd_pkg::CRC_INIT : r_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_cmd.load) begin
            n_crc = cfd_pkg::crc_word(w_base, i_cmd.word);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= cfd_pkg::CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

endmodule

[rtl/core/crc32_framed_packet_deframer_unit.sv]
// Top level of the CRC-32 framed packet deframer: header hunt, payload store, output drain.
// Depends on cfd_pkg, cfd_in_if, cfd_out_if and cfd_crc_unit.
//
//   channel   dir  transfer when        payload
//   i_in      in   valid && ready       rx_byte[7:0]
//   o_out     out  valid && ready       status[1:0], payload_byte[7:0], last
//   i_cfg_*   in   i_cfg_we             i_cfg_idx[1:0], i_cfg_data[7:0]
//
// One byte is taken per cycle unless a frame-ending byte waits. A good frame with N payload bytes drains N
// results from a two-bank payload RAM, one per cycle unless the output stalls, through a registered read port
// and the output register. A byte that ends a frame or gives a length error waits while a drain runs.
// A CRC word is folded in during the cycle that takes its last byte.
// Reset is synchronous, active low; the payload RAM needs no clearing pass.
`timescale 1ns / 1ps

module crc32_framed_packet_deframer_unit #(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfd_in_if.sink     i_in,
    cfd_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    localparam int IW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int MEM_WORDS = 2 ** (IW + 1);
    localparam logic [7:0] DEPTH_B = 8'(PAYLOAD_DEPTH);

    // configuration
    logic [7:0] r_sync1;
    logic [7:0] r_sync2;
    logic [7:0] r_sync3;
    logic [6:0] r_max_len;

    // parser state
    cfd_pkg::t_phase r_phase;
    cfd_pkg::t_phase n_phase;
    logic [6:0]  r_len;
    logic [6:0]  n_len;
    logic [7:0]  r_cnt;
    logic [7:0]  n_cnt;
    logic [31:0] r_word;
    logic [31:0] n_word;
    logic [23:0] r_rx_crc;
    logic [23:0] n_rx_crc;
    logic        r_wr_bank;

    // drain and output
    logic        r_drain_active;
    logic [7:0]  r_drain_idx;
    logic [6:0]  r_drain_len;
    logic        r_drain_bank;
    logic        r_rd_pend;
    logic        r_rd_last;
    logic [7:0]  r_rd_data;
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic [7:0]  r_mem [MEM_WORDS];

    cfd_pkg::t_crc_cmd w_crc_cmd;
    logic [31:0] w_crc;
    logic [7:0]  w_b;
    logic [7:0]  w_limit;
    logic        w_len_err;
    logic        w_crc_end;
    logic [31:0] w_rx_full;
    logic        w_crc_bad;
    logic        w_status_req;
    logic        w_drain_req;
    logic        w_busy;
    logic        w_out_free;
    logic        w_accept;
    logic        w_mem_we;
    logic        w_start_drain;
    cfd_pkg::t_status w_status;
    logic        w_rd_move;
    logic        w_rd_issue;
    logic [7:0]  w_cnt_inc;
    logic [31:0] w_word_in;

    function automatic logic [31:0] place_byte(input logic [31:0] word, input logic [7:0] b,
                                               input logic [1:0] k);
        logic [31:0] w;
        w = word;
        unique case (k)
            2'd0: w[7:0]   = b;
            2'd1: w[15:8]  = b;
            2'd2: w[23:16] = b;
            2'd3: w[31:24] = b;
        endcase
        return w;
    endfunction

    cfd_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_crc_cmd),
        .o_crc   (w_crc)
    );

    assign w_b       = i_in.rx_byte;
    assign w_limit   = ({1'b0, r_max_len} > DEPTH_B) ? DEPTH_B : {1'b0, r_max_len};
    assign w_len_err = (w_b > w_limit);
    assign w_crc_end = (r_phase == cfd_pkg::PH_CRC) && (r_cnt[1:0] == 2'd3);
    assign w_rx_full = {w_b, r_rx_crc};
    assign w_crc_bad = (w_rx_full != w_crc);
    assign w_cnt_inc = r_cnt + 8'd1;
    assign w_word_in = place_byte(r_word, w_b, r_cnt[1:0]);

    assign w_status_req = ((r_phase == cfd_pkg::PH_LEN) && w_len_err)
                       || (w_crc_end && (w_crc_bad || (r_len == 7'd0)));
    assign w_drain_req  = w_crc_end && !w_crc_bad && (r_len != 7'd0);
    assign w_busy       = r_drain_active || r_rd_pend;
    assign w_out_free   = !r_out_valid || o_out.ready;

    // hold bytes that end a frame until the drain is idle and, for a status result, the output stage is free
    assign i_in.ready = !(w_status_req || w_drain_req)
                     || (!w_busy && (w_out_free || !w_status_req));
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_word    = r_word;
        n_rx_crc  = r_rx_crc;
        w_crc_cmd = '{load: 1'b0, fresh: 1'b0, word: 32'd0};
        w_mem_we  = 1'b0;
        w_start_drain = 1'b0;
        w_status  = cfd_pkg::ST_CRC_ERR;
        if (w_accept) begin
            unique case (r_phase)
                cfd_pkg::PH_H1: begin
                    if (w_b == r_sync1) begin
                        n_phase = cfd_pkg::PH_H2;
                    end
                end
                cfd_pkg::PH_H2: begin
                    priority if (w_b == r_sync2) begin
                        n_phase = cfd_pkg::PH_H3;
                    end else if (w_b == r_sync1) begin
                        n_phase = cfd_pkg::PH_H2;
                    end else begin
                        n_phase = cfd_pkg::PH_H1;
                    end
                end
                cfd_pkg::PH_H3: begin
                    priority if (w_b == r_sync3) begin
                        n_phase = cfd_pkg::PH_LEN;
                    end else if ((w_b == r_sync2) && (r_sync1 == r_sync2)) begin
                        n_phase = cfd_pkg::PH_H3;
                    end else if (w_b == r_sync1) begin
                        n_phase = cfd_pkg::PH_H2;
                    end else begin
                        n_phase = cfd_pkg::PH_H1;
                    end
                end
                cfd_pkg::PH_LEN: begin
                    if (w_len_err) begin
                        n_phase  = cfd_pkg::PH_H1;
                        w_status = cfd_pkg::ST_LEN_ERR;
                    end else begin
                        w_crc_cmd = '{load: 1'b1, fresh: 1'b1,
                                      word: {w_b, r_sync3, r_sync2, r_sync1}};
                        n_word   = 32'd0;
                        n_len    = w_b[6:0];
                        n_cnt    = 8'd0;
                        n_rx_crc = 24'd0;
                        n_phase  = (w_b == 8'd0) ? cfd_pkg::PH_CRC : cfd_pkg::PH_DATA;
                    end
                end
                cfd_pkg::PH_DATA: begin
                    w_mem_we = 1'b1;
                    n_word   = w_word_in;
                    n_cnt    = w_cnt_inc;
                    if ((r_cnt[1:0] == 2'd3) || (w_cnt_inc >= {1'b0, r_len})) begin
                        w_crc_cmd = '{load: 1'b1, fresh: 1'b0, word: w_word_in};
                        n_word    = 32'd0;
                    end
                    if (w_cnt_inc >= {1'b0, r_len}) begin
                        n_cnt    = 8'd0;
                        n_rx_crc = 24'd0;
                        n_phase  = cfd_pkg::PH_CRC;
                    end
                end
                cfd_pkg::PH_CRC: begin
                    n_rx_crc = 24'(place_byte({8'd0, r_rx_crc}, w_b, r_cnt[1:0]));
                    n_cnt    = w_cnt_inc;
                    if (w_crc_end) begin
                        n_phase = cfd_pkg::PH_H1;
                        n_cnt   = 8'd0;
                        priority if (w_crc_bad) begin
                            w_status = cfd_pkg::ST_CRC_ERR;
                        end else if (r_len == 7'd0) begin
                            w_status = cfd_pkg::ST_EMPTY_OK;
                        end else begin
                            w_start_drain = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = cfd_pkg::PH_H1;
                end
            endcase
        end
    end

    assign w_rd_move  = r_rd_pend && w_out_free;
    assign w_rd_issue = r_drain_active && (!r_rd_pend || w_rd_move);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync1   <= 8'd0;
            r_sync2   <= 8'd0;
            r_sync3   <= 8'd0;
            r_max_len <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (cfd_pkg::t_cfg_idx'(i_cfg_idx))
                cfd_pkg::CFG_SYNC_FIRST:  r_sync1   <= i_cfg_data;
                cfd_pkg::CFG_SYNC_SECOND: r_sync2   <= i_cfg_data;
                cfd_pkg::CFG_SYNC_THIRD:  r_sync3   <= i_cfg_data;
                cfd_pkg::CFG_MAX_LEN:     r_max_len <= i_cfg_data[6:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= cfd_pkg::PH_H1;
            r_len     <= 7'd0;
            r_cnt     <= 8'd0;
            r_word    <= 32'd0;
            r_rx_crc  <= 24'd0;
            r_wr_bank <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_word   <= n_word;
            r_rx_crc <= n_rx_crc;
            if (w_start_drain) begin
                r_wr_bank <= !r_wr_bank;
            end
        end
    end

    // payload RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[{r_wr_bank, r_cnt[IW-1:0]}] <= w_b;
        end
        if (w_rd_issue) begin
            r_rd_data <= r_mem[{r_drain_bank, r_drain_idx[IW-1:0]}];
            r_rd_last <= (r_drain_idx + 8'd1) == {1'b0, r_drain_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain_active <= 1'b0;
            r_drain_idx    <= 8'd0;
            r_rd_pend      <= 1'b0;
        end else begin
            if (w_start_drain) begin
                r_drain_active <= 1'b1;
                r_drain_idx    <= 8'd0;
            end else if (w_rd_issue) begin
                r_drain_idx <= r_drain_idx + 8'd1;
                if ((r_drain_idx + 8'd1) == {1'b0, r_drain_len}) begin
                    r_drain_active <= 1'b0;
                end
            end
            if (w_rd_issue) begin
                r_rd_pend <= 1'b1;
            end else if (w_rd_move) begin
                r_rd_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start_drain) begin
            r_drain_len  <= r_len;
            r_drain_bank <= r_wr_bank;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_rd_pend || (w_accept && w_status_req);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_rd_pend) begin
                r_out_status <= cfd_pkg::ST_PAYLOAD;
                r_out_byte   <= r_rd_data;
                r_out_last   <= r_rd_last;
            end else begin
                r_out_status <= w_status;
                r_out_byte   <= 8'd0;
                r_out_last   <= 1'b1;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.payload_byte = r_out_byte;
    assign o_out.last         = r_out_last;

endmodule
